FILE: rtl/wgc_pkg.sv
// ----------------------------------------------------------------------------
// wgc_pkg: shared constants for the waypoint go-to-goal controller
// Fixed-point formats, CORDIC sizing, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
package wgc_pkg;

   // Number of configured waypoints in use (1 to 3) and CORDIC iterations (8 to 24)
   localparam int NUM_WAYPOINTS = 3;
   localparam int CORDIC_STEPS  = 16;
   localparam int STEP_W        = $clog2(CORDIC_STEPS);

   // Field widths
   localparam int POS_W  = 16;   // Q4.12 unsigned positions
   localparam int HEAD_W = 15;   // Q3.12 signed heading
   localparam int LIN_W  = 15;   // Q3.12 unsigned forward speed
   localparam int VEL_W  = 16;   // Q4.12 signed turn rate
   localparam int GAIN_W = 16;   // Q4.12 unsigned gains and radius
   localparam int IDX_W  = 2;

   // Datapath widths
   localparam int DIFF_W     = POS_W + 1;                // target minus pose
   localparam int EXTRA_BITS = 8;                        // extra fraction bits in CORDIC
   localparam int XY_W       = DIFF_W + EXTRA_BITS + 3;  // room for CORDIC gain and sign
   localparam int MAG_W      = XY_W - 1;
   localparam int Z_W        = 34;                       // Q2.30 angle with headroom
   localparam int ATAN_W     = 30;
   localparam int THETA_SH   = 18;                       // Q2.30 to Q3.12
   localparam int THETA_W    = Z_W - THETA_SH;
   localparam int DIST_W     = 17;
   localparam int DIST_SH    = 30 + EXTRA_BITS;
   localparam int ERR_W      = 17;
   localparam int LINRAW_W   = 21;
   localparam int ANGRAW_W   = 20;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int Q_SH       = 12;

   // Constants
   localparam logic signed [Z_W-1:0]   PI_Q30      = 34'sd3373259426;
   localparam logic signed [MUL_W-1:0] INVK_Q30    = 32'sd652032874;
   localparam logic signed [ERR_W-1:0] PI_Q12      = 17'sd12868;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q12  = 17'sd25736;
   localparam logic signed [ERR_W-1:0] ERR_CUT_Q12 = 17'sd2867;
   localparam logic signed [MUL_W-1:0] CUT_Q12     = 32'sd819;

   // Register indexes on the configuration port
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_WAYPOINT_A    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAYPOINT_B    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WAYPOINT_C    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ARRIVE_RADIUS = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIN_GAIN      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ANG_GAIN      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LIN_LIMIT     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ANG_LIMIT     = 4'd7;

   // Arctangent of 2^-i in Q2.30, truncated
   function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] i);
      logic [ATAN_W-1:0] v;
      case (i)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/wgc_mul.sv
// ----------------------------------------------------------------------------
// wgc_mul: shared signed multiplier
// One registered multiply per cycle; the sequencer steers its operands.
// ----------------------------------------------------------------------------
module wgc_mul (
   input  logic                               clock,
   input  logic signed [wgc_pkg::MUL_W-1:0]   mul_a,
   input  logic signed [wgc_pkg::MUL_W-1:0]   mul_b,
   output logic signed [wgc_pkg::PROD_W-1:0]  prod_ff
);

   logic signed [wgc_pkg::PROD_W-1:0] prod_in;

   // Form the full-width product
   assign prod_in = wgc_pkg::PROD_W'(mul_a) * wgc_pkg::PROD_W'(mul_b);

   // Register it
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: rtl/wgc_cordic.sv
// ----------------------------------------------------------------------------
// wgc_cordic: iterative vectoring CORDIC
// Rotates (dx, dy) onto the x axis one step per cycle, accumulating the angle.
// ----------------------------------------------------------------------------
module wgc_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [wgc_pkg::DIFF_W-1:0]  dx,
   input  logic signed [wgc_pkg::DIFF_W-1:0]  dy,
   output logic                               done_ff,
   output logic        [wgc_pkg::MAG_W-1:0]   mag_x,
   output logic signed [wgc_pkg::Z_W-1:0]     z_ff
);

   logic signed [wgc_pkg::XY_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [wgc_pkg::Z_W-1:0]   z_in;
   logic        [wgc_pkg::STEP_W-1:0] step_ff, step_in;
   logic                             busy_ff, busy_in, done_in;
   logic signed [wgc_pkg::XY_W-1:0]  x0, y0, xs, ys;
   logic signed [wgc_pkg::Z_W-1:0]   atan_v;

   // Scale the offsets up and take the shifted terms of the current step
   assign x0     = wgc_pkg::XY_W'(dx) <<< wgc_pkg::EXTRA_BITS;
   assign y0     = wgc_pkg::XY_W'(dy) <<< wgc_pkg::EXTRA_BITS;
   assign xs     = x_ff >>> step_ff;
   assign ys     = y_ff >>> step_ff;
   assign atan_v = signed'(wgc_pkg::Z_W'(wgc_pkg::atan_q30(5'(step_ff))));

   // Magnitude before gain correction, negative clipped to zero
   assign mag_x = x_ff[wgc_pkg::XY_W-1] ? '0 : x_ff[wgc_pkg::MAG_W-1:0];

   // Next-state logic: load and fold into the right half plane, then rotate
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
         if (x0 < 0) begin
            x_in = -x0;
            y_in = -y0;
            z_in = (y0 >= 0) ? wgc_pkg::PI_Q30 : -wgc_pkg::PI_Q30;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_v;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_v;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == wgc_pkg::STEP_W'(wgc_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

endmodule

FILE: rtl/waypoint_go_to_goal_controller_top.sv
// ----------------------------------------------------------------------------
// waypoint_go_to_goal_controller_top: unicycle go-to-goal steering controller
// Steers each pose sample toward the current waypoint or external goal.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Carries
//  req_     in         req_tvalid/tready     pose sample or goal update
//  rsp_     out        rsp_tvalid/tready     speed command and status
//  csr_     in         csr_valid/csr_ready   register index and write data
//
//  A pose sample runs through the iterative CORDIC loop and then the states
//  that use the single shared multiplier before its result is ready. A goal
//  update is taken without a result (and ignored once the route is finished);
//  a pose sample once all waypoints are done goes straight to the output. req_tready is low while a sample
//  is in work and while its result waits for the output register to free up.
//  Reset is synchronous; configuration writes are always taken.
// ----------------------------------------------------------------------------
module waypoint_go_to_goal_controller_top (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pos_x[15:0], pos_y[31:16], heading[46:32]
   input  logic [0:0]  req_tuser,   // func[0]
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // lin_vel[14:0], ang_vel[30:15], target_slot[32:31]
   output logic [2:0]  rsp_tuser,   // arrived[0], external_mode[1], done_res[2]
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [wgc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_data
);

   typedef struct packed {
      logic        [wgc_pkg::LIN_W-1:0] lin_vel;
      logic signed [wgc_pkg::VEL_W-1:0] ang_vel;
      logic                             arrived;
      logic        [wgc_pkg::IDX_W-1:0] target_slot;
      logic                             external_mode;
      logic                             done_res;
   } result_type;

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CORD = 3'd1;
   localparam logic [2:0] S_MAG  = 3'd2;
   localparam logic [2:0] S_WRAP = 3'd3;
   localparam logic [2:0] S_LIN  = 3'd4;
   localparam logic [2:0] S_CUT  = 3'd5;
   localparam logic [2:0] S_ANG  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0] state_ff, state_in;

   // Configuration registers
   logic [31:0]                  wp_ff [3];
   logic [31:0]                  wp_in [3];
   logic [wgc_pkg::GAIN_W-1:0]   radius_ff, radius_in, lin_gain_ff, lin_gain_in;
   logic [wgc_pkg::GAIN_W-1:0]   ang_gain_ff, ang_gain_in;
   logic [wgc_pkg::LIN_W-1:0]    lin_limit_ff, lin_limit_in, ang_limit_ff, ang_limit_in;

   // Target-tracking state
   logic                         use_ext_ff, use_ext_in;
   logic [wgc_pkg::POS_W-1:0]    goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [wgc_pkg::IDX_W-1:0]    idx_ff, idx_in;

   // Working registers
   logic signed [wgc_pkg::HEAD_W-1:0]  hd_ff, hd_in;
   logic        [wgc_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic signed [wgc_pkg::ERR_W-1:0]   err_ff, err_in;
   logic        [wgc_pkg::LINRAW_W-1:0] lin_ff, lin_in;
   result_type                         res_ff, res_in, rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // Input fields and derived values
   logic                               in_func;
   logic [wgc_pkg::POS_W-1:0]          in_x, in_y;
   logic signed [wgc_pkg::HEAD_W-1:0]  in_head;
   logic                               req_fire, done_now, cut;
   logic [wgc_pkg::IDX_W-1:0]          wsel;
   logic [wgc_pkg::POS_W-1:0]          tx, ty;
   logic signed [wgc_pkg::DIFF_W-1:0]  dx, dy;
   logic signed [wgc_pkg::THETA_W-1:0] theta;
   logic        [wgc_pkg::LINRAW_W-1:0] lin_prod;
   logic signed [wgc_pkg::ANGRAW_W-1:0] ang_raw, ang_lim;
   logic        [wgc_pkg::LIN_W-1:0]    lin_sat;
   logic signed [wgc_pkg::VEL_W-1:0]    ang_sat;

   // Shared units
   logic                                cord_start, cord_done;
   logic        [wgc_pkg::MAG_W-1:0]    cord_mag;
   logic signed [wgc_pkg::Z_W-1:0]      cord_z;
   logic signed [wgc_pkg::MUL_W-1:0]    mul_a, mul_b;
   logic signed [wgc_pkg::PROD_W-1:0]   prod;

   wgc_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .dx      (dx),
      .dy      (dy),
      .done_ff (cord_done),
      .mag_x   (cord_mag),
      .z_ff    (cord_z)
   );

   wgc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   // Unpack the input transaction
   assign in_func  = req_tuser[0];
   assign in_x     = req_tdata[15:0];
   assign in_y     = req_tdata[31:16];
   assign in_head  = signed'(req_tdata[46:32]);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Select the target and form the offset from the pose
   assign done_now = !use_ext_ff && (idx_ff >= wgc_pkg::IDX_W'(wgc_pkg::NUM_WAYPOINTS));
   assign wsel     = (idx_ff == 2'd3) ? 2'd2 : idx_ff;
   assign tx       = use_ext_ff ? goal_x_ff : wp_ff[wsel][31:16];
   assign ty       = use_ext_ff ? goal_y_ff : wp_ff[wsel][15:0];
   assign dx       = signed'({1'b0, tx}) - signed'({1'b0, in_x});
   assign dy       = signed'({1'b0, ty}) - signed'({1'b0, in_y});
   assign cord_start = req_fire && !in_func && !done_now;

   // Product slices and result saturation
   assign theta    = cord_z[wgc_pkg::Z_W-1:wgc_pkg::THETA_SH];
   assign lin_prod = prod[wgc_pkg::Q_SH+wgc_pkg::LINRAW_W-1:wgc_pkg::Q_SH];
   assign ang_raw  = prod[wgc_pkg::Q_SH+wgc_pkg::ANGRAW_W-1:wgc_pkg::Q_SH];
   assign ang_lim  = signed'(wgc_pkg::ANGRAW_W'(ang_limit_ff));
   assign cut      = (err_ff > wgc_pkg::ERR_CUT_Q12) || (err_ff < -wgc_pkg::ERR_CUT_Q12);
   assign lin_sat  = (lin_ff > wgc_pkg::LINRAW_W'(lin_limit_ff)) ? lin_limit_ff
                                                                 : lin_ff[wgc_pkg::LIN_W-1:0];
   always_comb begin
      if (ang_raw > ang_lim) begin
         ang_sat = ang_lim[wgc_pkg::VEL_W-1:0];
      end else if (ang_raw < -ang_lim) begin
         ang_sat = 16'(-ang_lim);
      end else begin
         ang_sat = ang_raw[wgc_pkg::VEL_W-1:0];
      end
   end

   // Steer the multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_CORD: begin
            mul_a = signed'(wgc_pkg::MUL_W'(cord_mag));
            mul_b = wgc_pkg::INVK_Q30;
         end
         S_WRAP: begin
            mul_a = signed'(wgc_pkg::MUL_W'(lin_gain_ff));
            mul_b = signed'(wgc_pkg::MUL_W'(dist_ff));
         end
         S_LIN: begin
            if (cut) begin
               mul_a = signed'(wgc_pkg::MUL_W'(lin_prod));
               mul_b = wgc_pkg::CUT_Q12;
            end else begin
               mul_a = signed'(wgc_pkg::MUL_W'(ang_gain_ff));
               mul_b = wgc_pkg::MUL_W'(err_ff);
            end
         end
         S_CUT: begin
            mul_a = signed'(wgc_pkg::MUL_W'(ang_gain_ff));
            mul_b = wgc_pkg::MUL_W'(err_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Configuration write decode
   always_comb begin
      wp_in        = wp_ff;
      radius_in    = radius_ff;
      lin_gain_in  = lin_gain_ff;
      ang_gain_in  = ang_gain_ff;
      lin_limit_in = lin_limit_ff;
      ang_limit_in = ang_limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wgc_pkg::REG_WAYPOINT_A:    wp_in[0]     = csr_data;
            wgc_pkg::REG_WAYPOINT_B:    wp_in[1]     = csr_data;
            wgc_pkg::REG_WAYPOINT_C:    wp_in[2]     = csr_data;
            wgc_pkg::REG_ARRIVE_RADIUS: radius_in    = csr_data[15:0];
            wgc_pkg::REG_LIN_GAIN:      lin_gain_in  = csr_data[15:0];
            wgc_pkg::REG_ANG_GAIN:      ang_gain_in  = csr_data[15:0];
            wgc_pkg::REG_LIN_LIMIT:     lin_limit_in = csr_data[14:0];
            wgc_pkg::REG_ANG_LIMIT:     ang_limit_in = csr_data[14:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      use_ext_in   = use_ext_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      idx_in       = idx_ff;
      hd_in        = hd_ff;
      dist_in      = dist_ff;
      err_in       = err_ff;
      lin_in       = lin_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (in_func) begin
                  // Latch a new external goal unless the route is finished
                  if (!done_now) begin
                     use_ext_in = 1'b1;
                     goal_x_in  = in_x;
                     goal_y_in  = in_y;
                  end
               end else if (done_now) begin
                  res_in     = '{lin_vel: '0, ang_vel: '0, arrived: 1'b0,
                                 target_slot: 2'd3, external_mode: 1'b0, done_res: 1'b1};
                  state_in   = S_OUT;
               end else begin
                  hd_in    = in_head;
                  state_in = S_CORD;
               end
            end
         end
         S_CORD: begin
            if (cord_done) begin
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            // Gain-corrected distance and raw heading error
            dist_in  = prod[wgc_pkg::DIST_SH+wgc_pkg::DIST_W-1:wgc_pkg::DIST_SH];
            err_in   = wgc_pkg::ERR_W'(theta) - wgc_pkg::ERR_W'(hd_ff);
            state_in = S_WRAP;
         end
         S_WRAP: begin
            if (dist_ff < wgc_pkg::DIST_W'(radius_ff)) begin
               // Arrived: stop, and advance along the route unless on an external goal
               res_in = '{lin_vel: '0, ang_vel: '0, arrived: 1'b1, target_slot: idx_ff,
                          external_mode: use_ext_ff, done_res: 1'b0};
               if (!use_ext_ff) begin
                  idx_in = idx_ff + 1'b1;
               end
               state_in = S_OUT;
            end else if (err_ff > wgc_pkg::PI_Q12) begin
               err_in = err_ff - wgc_pkg::TWO_PI_Q12;
            end else if (err_ff < -wgc_pkg::PI_Q12) begin
               err_in = err_ff + wgc_pkg::TWO_PI_Q12;
            end else begin
               state_in = S_LIN;
            end
         end
         S_LIN: begin
            if (cut) begin
               state_in = S_CUT;
            end else begin
               lin_in   = lin_prod;
               state_in = S_ANG;
            end
         end
         S_CUT: begin
            lin_in   = lin_prod;
            state_in = S_ANG;
         end
         S_ANG: begin
            res_in   = '{lin_vel: lin_sat, ang_vel: ang_sat, arrived: 1'b0,
                         target_slot: idx_ff, external_mode: use_ext_ff, done_res: 1'b0};
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         use_ext_ff   <= 1'b0;
         goal_x_ff    <= 16'd24576;
         goal_y_ff    <= 16'd24576;
         idx_ff       <= '0;
         wp_ff[0]     <= 32'd1610637312;
         wp_ff[1]     <= 32'd536895488;
         wp_ff[2]     <= 32'd2147491840;
         radius_ff    <= 16'd819;
         lin_gain_ff  <= 16'd6144;
         ang_gain_ff  <= 16'd24576;
         lin_limit_ff <= 15'd8192;
         ang_limit_ff <= 15'd16384;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         use_ext_ff   <= use_ext_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         idx_ff       <= idx_in;
         wp_ff        <= wp_in;
         radius_ff    <= radius_in;
         lin_gain_ff  <= lin_gain_in;
         ang_gain_ff  <= ang_gain_in;
         lin_limit_ff <= lin_limit_in;
         ang_limit_ff <= ang_limit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hd_ff   <= hd_in;
      dist_ff <= dist_in;
      err_ff  <= err_in;
      lin_ff  <= lin_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // Pack the result transaction
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.target_slot, rsp_ff.ang_vel, rsp_ff.lin_vel};
   assign rsp_tuser  = {rsp_ff.done_res, rsp_ff.external_mode, rsp_ff.arrived};

endmodule

FILE: rtl/wgc_checker.sv
// ----------------------------------------------------------------------------
// wgc_checker: port-level checks for the go-to-goal controller
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module wgc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A pose sample keeps the block busy for the following cycle
   a_pose_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] |=> !req_tready)
      else $error("input taken again straight after a pose sample");

   // Arrival always comes with zero speeds
   a_arrive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[30:0] == 31'd0 && !rsp_tuser[2])
      else $error("arrival with non-zero speed");

   // Finished route reports slot three, stopped, not external
   a_done_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |->
         rsp_tdata[30:0] == 31'd0 && rsp_tdata[32:31] == 2'd3 && rsp_tuser[1:0] == 2'b00)
      else $error("malformed done result");

endmodule

bind waypoint_go_to_goal_controller_top wgc_checker u_wgc_checker (.*);
